// File: src/gbhi_pkg.sv
// shared types and constants for the gyro bias calibration and heading integrator
`default_nettype none
package gbhi_pkg;

	// fixed field widths
	localparam int RAW_W     = 16;
	localparam int RATE_W    = 25;
	localparam int HEAD_W    = 48;
	localparam int CNT_W     = 8;
	localparam int SUM_W     = 23;
	localparam int OFS_W     = 24;
	localparam int STEP_W    = 28;

	// calibration counter value that marks no calibration running
	localparam logic [CNT_W-1:0] CNT_IDLE = 8'hFF;

	// saturation limits
	localparam logic [SUM_W-1:0]  SUM_MAX  = 23'h3FFFFF;
	localparam logic [SUM_W-1:0]  SUM_MIN  = 23'h400000;
	localparam logic [HEAD_W-1:0] HEAD_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [HEAD_W-1:0] HEAD_MIN = 48'h8000_0000_0000;
	localparam logic [OFS_W-1:0]  OFS_MAX  = 24'h7FFFFF;
	localparam logic [OFS_W-1:0]  OFS_MIN  = 24'h800000;

	// offset divider: quotient of |sum| * 256, split into |sum| / d and (rem * 256) / d
	localparam int DIV_W     = SUM_W + 8;
	localparam int RCP1_SH   = SUM_W + CNT_W;
	localparam int RCP1_W    = 32;
	localparam int P1_W      = SUM_W + RCP1_SH;
	localparam int RCP2_SH   = 3 * CNT_W;
	localparam int RCP2_W    = 25;
	localparam int P2_W      = 32;

	// command queue depth
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// input item
	typedef struct packed {
		logic                    kind;
		logic signed [RAW_W-1:0] raw_rate;
	} in_item_t;

	// result item
	typedef struct packed {
		logic signed [RATE_W-1:0] rate;
		logic signed [HEAD_W-1:0] heading;
		logic                     calibrating;
	} out_item_t;

	// decoded operation
	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_START  = 1'b1
	} op_t;

	// command passed from front to back
	typedef struct packed {
		op_t                     op;
		logic [RATE_W-1:0]       raw_q8;
	} cmd_t;

	// request to the offset divider
	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  sum;
	} div_req_t;

endpackage
`default_nettype wire

// File: src/gyro_bias_calibrate_heading_integrate_core.sv
// top level of the gyro bias calibration and heading integrator
//
//  channel   dir  handshake                    payload
//  sample    in   sample_valid / sample_ready  sample : in_item_t  (kind, raw_rate)
//  result    out  result_valid / result_ready  result : out_item_t (rate, heading, calibrating)
//
// one transfer per cycle sustained while result_ready is high and the divider is idle
// the sample that ends a calibration holds the back end while the
// offset divider runs its three-stage reciprocal multiply
// reset is asynchronous: calibration idle, sum, offset and heading cleared
// a stalled result backs up into the two-entry queue, then the front register
`default_nettype none
module gyro_bias_calibrate_heading_integrate_core #(
	parameter int CALIB_SAMPLES = 100
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_ready,
	input  wire gbhi_pkg::in_item_t  sample,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output gbhi_pkg::out_item_t      result
);
	import gbhi_pkg::*;

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	// decode and register incoming transfers
	gbhi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.cmd_valid    (front_valid),
		.cmd_ready    (front_ready),
		.cmd          (front_cmd)
	);

	// decouple front from back
	gbhi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	// execute commands
	gbhi_back #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_pop      (q_pop),
		.cmd          (q_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// File: src/gbhi_front.sv
// front stage: takes input transfers, decodes them and hands commands to the queue
`default_nettype none
module gbhi_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sample_valid,
	output logic                  sample_ready,
	input  wire gbhi_pkg::in_item_t sample,
	output logic                  cmd_valid,
	input  wire logic             cmd_ready,
	output gbhi_pkg::cmd_t        cmd
);
	import gbhi_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic take;

	// decode kind and prescale the sample to LSB/256
	always_comb begin
		dec.op     = sample.kind ? OP_START : OP_SAMPLE;
		dec.raw_q8 = {sample.raw_rate[RAW_W-1], sample.raw_rate, 8'h00};
	end

	assign sample_ready = !vld_s1 || cmd_ready;
	assign take         = sample_valid && sample_ready;
	assign cmd_valid    = vld_s1;
	assign cmd          = cmd_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (cmd_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= dec;
		end
	end

endmodule
`default_nettype wire

// File: src/gbhi_queue.sv
// two-entry command queue between front and back
`default_nettype none
module gbhi_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                push_ready,
	input  wire gbhi_pkg::cmd_t push_cmd,
	output logic                pop_valid,
	input  wire logic           pop,
	output gbhi_pkg::cmd_t      pop_cmd
);
	import gbhi_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// File: src/gbhi_ofs_div.sv
// offset divider: (sum * 256) / CALIB_SAMPLES by reciprocal multiplication in three stages
`default_nettype none
module gbhi_ofs_div #(
	parameter int CALIB_SAMPLES = 100
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gbhi_pkg::div_req_t req,
	output logic                    busy,
	output logic [gbhi_pkg::OFS_W-1:0] offset_q8
);
	import gbhi_pkg::*;

	// reciprocals floor(2^k / d) + 1, exact over the dividend ranges used
	localparam logic [CNT_W-1:0]  DIVISOR = CNT_W'(CALIB_SAMPLES);
	localparam logic [RCP1_W-1:0] RCP1    =
		RCP1_W'((longint'(1) << RCP1_SH) / longint'(CALIB_SAMPLES) + 1);
	localparam logic [RCP2_W-1:0] RCP2    =
		RCP2_W'((longint'(1) << RCP2_SH) / longint'(CALIB_SAMPLES) + 1);

	logic                 vld_s1;
	logic                 vld_s2;
	logic                 vld_s3;
	logic                 neg_s1;
	logic                 neg_s2;
	logic                 neg_s3;
	logic [SUM_W-1:0]     abs_s1;
	logic [SUM_W-1:0]     abs_s2;
	logic [SUM_W-1:0]     quo_s2;
	logic [SUM_W-1:0]     quo_s3;
	logic [CNT_W-1:0]     rem_s3;
	logic [OFS_W-1:0]     ofs_q;

	logic [SUM_W-1:0]     sum_abs;
	logic [P1_W-1:0]      prod1;
	logic [SUM_W-1:0]     quo_d;
	logic [SUM_W-1:0]     rem_full;
	logic [P2_W-1:0]      prod2;
	logic [DIV_W-1:0]     quo;
	logic [OFS_W-1:0]     ofs_nx;

	assign sum_abs = req.sum[SUM_W-1] ? (SUM_W'(0) - req.sum) : req.sum;

	// stage 1: coarse quotient |sum| / d
	assign prod1 = P1_W'(abs_s1) * P1_W'(RCP1);

	// stage 2: remainder of the coarse quotient
	assign quo_d    = quo_s2 * SUM_W'(DIVISOR);
	assign rem_full = abs_s2 - quo_d;

	// stage 3: low eight quotient bits from (rem * 256) / d
	assign prod2 = P2_W'({rem_s3, 8'h00}) * P2_W'(RCP2);
	assign quo   = {quo_s3, prod2[RCP2_SH+CNT_W-1:RCP2_SH]};

	// sign and saturate the quotient
	always_comb begin
		if (neg_s3) begin
			ofs_nx = (quo > DIV_W'(OFS_MIN)) ? OFS_MIN
				: (OFS_W'(0) - quo[OFS_W-1:0]);
		end else begin
			ofs_nx = (quo > DIV_W'(OFS_MAX)) ? OFS_MAX : quo[OFS_W-1:0];
		end
	end

	assign busy      = vld_s1 || vld_s2 || vld_s3;
	assign offset_q8 = ofs_q;

	// stage valids and offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			ofs_q  <= '0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (vld_s3) begin
				ofs_q <= ofs_nx;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_s1 <= req.sum[SUM_W-1];
			abs_s1 <= sum_abs;
		end
		if (vld_s1) begin
			neg_s2 <= neg_s1;
			abs_s2 <= abs_s1;
			quo_s2 <= prod1[RCP1_SH+SUM_W-1:RCP1_SH];
		end
		if (vld_s2) begin
			neg_s3 <= neg_s2;
			quo_s3 <= quo_s2;
			rem_s3 <= rem_full[CNT_W-1:0];
		end
	end

endmodule
`default_nettype wire

// File: src/gbhi_back.sv
// back end: calibration sum, offset removal, heading integration and result register
`default_nettype none
module gbhi_back #(
	parameter int CALIB_SAMPLES = 100
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_pop,
	input  wire gbhi_pkg::cmd_t  cmd,
	output logic                 result_valid,
	input  wire logic            result_ready,
	output gbhi_pkg::out_item_t  result
);
	import gbhi_pkg::*;

	localparam logic [CNT_W-1:0] SAMPLES = CNT_W'(CALIB_SAMPLES);

	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [HEAD_W-1:0] heading_q;
	logic              out_vld_q;
	out_item_t         out_q;

	div_req_t          div_req;
	logic              div_busy;
	logic [OFS_W-1:0]  offset_q8;

	logic [RAW_W-1:0]  raw;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_sat;
	logic [CNT_W-1:0]  cnt_inc;
	logic [RATE_W-1:0] corr;
	logic [STEP_W-1:0] step;
	logic [HEAD_W:0]   head_ext;
	logic [HEAD_W-1:0] head_sat;

	logic [CNT_W-1:0]  count_nx;
	logic [SUM_W-1:0]  sum_nx;
	logic [HEAD_W-1:0] heading_nx;
	out_item_t         res_nx;

	gbhi_ofs_div #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.busy      (div_busy),
		.offset_q8 (offset_q8)
	);

	// take a command when the divider is free and the result slot opens
	assign cmd_pop = cmd_valid && !div_busy && (!out_vld_q || result_ready);

	// calibration sum with saturation
	always_comb begin
		raw     = cmd.raw_q8[RATE_W-2:8];
		sum_ext = {sum_q[SUM_W-1], sum_q} + {{(SUM_W+1-RAW_W){raw[RAW_W-1]}}, raw};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
		cnt_inc = count_q + 1'b1;
	end

	// corrected rate and saturating heading step of rate*5
	always_comb begin
		corr     = cmd.raw_q8 - {offset_q8[OFS_W-1], offset_q8};
		step     = {corr[RATE_W-1], corr, 2'b00} + {{3{corr[RATE_W-1]}}, corr};
		head_ext = {heading_q[HEAD_W-1], heading_q}
			+ {{(HEAD_W+1-STEP_W){step[STEP_W-1]}}, step};
		if (head_ext[HEAD_W] != head_ext[HEAD_W-1]) begin
			head_sat = head_ext[HEAD_W] ? HEAD_MIN : HEAD_MAX;
		end else begin
			head_sat = head_ext[HEAD_W-1:0];
		end
	end

	// next state and result
	always_comb begin
		count_nx            = count_q;
		sum_nx              = sum_q;
		heading_nx          = heading_q;
		div_req.start       = 1'b0;
		div_req.sum         = sum_sat;
		res_nx.rate         = '0;
		res_nx.heading      = '0;
		res_nx.calibrating  = 1'b1;
		case (cmd.op)
			OP_START: begin
				count_nx   = '0;
				sum_nx     = '0;
				heading_nx = '0;
			end
			OP_SAMPLE: begin
				if (count_q != CNT_IDLE) begin
					sum_nx     = sum_sat;
					heading_nx = '0;
					if (cnt_inc >= SAMPLES) begin
						count_nx      = CNT_IDLE;
						div_req.start = cmd_pop;
					end else begin
						count_nx = cnt_inc;
					end
				end else begin
					heading_nx         = head_sat;
					res_nx.rate        = corr;
					res_nx.heading     = head_sat;
					res_nx.calibrating = 1'b0;
				end
			end
			default: begin
				count_nx = count_q;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CNT_IDLE;
			sum_q     <= '0;
			heading_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				count_q   <= count_nx;
				sum_q     <= sum_nx;
				heading_q <= heading_nx;
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_q <= res_nx;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule
`default_nettype wire

// File: test/gyro_bias_calibrate_heading_integrate_core_tb.sv
// testbench for the gyro bias calibration and heading integrator: directed and random samples
`timescale 1ns / 100ps
module gyro_bias_calibrate_heading_integrate_core_tb;
	import gbhi_pkg::*;

	localparam int CALIB_N = 100;

	// saturation limits of the expected-value model
	localparam longint SUM_HI  = 4194303;
	localparam longint SUM_LO  = -4194304;
	localparam longint OFS_HI  = 8388607;
	localparam longint OFS_LO  = -8388608;
	localparam longint HEAD_HI = (longint'(1) <<< 47) - 1;
	localparam longint HEAD_LO = -(longint'(1) <<< 47);

	logic      clk;
	logic      arst_n;
	logic      sample_valid;
	logic      sample_ready;
	in_item_t  sample;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;

	// expected-value state
	logic [CNT_W-1:0] cal_cnt;
	longint           cal_sum;
	longint           ofs_q8;
	longint           head_acc;

	out_item_t expected_results[$];
	int        errors;
	int        items_sent;
	bit        no_idle;
	bit        hold_req;

	gyro_bias_calibrate_heading_integrate_core #(
		.CALIB_SAMPLES(CALIB_N)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// 8 ns clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// advance the calibration, offset and heading state by one accepted item and give its result
	function automatic out_item_t integrate_sample(input in_item_t it);
		out_item_t o;
		longint    raw;
		longint    corr;
		longint    q;
		o = '0;
		raw = it.raw_rate;
		if (it.kind == OP_START) begin
			cal_sum = 0;
			cal_cnt = '0;
			head_acc = 0;
			o.calibrating = 1'b1;
		end else if (cal_cnt != CNT_IDLE) begin
			cal_sum = clamp_to(cal_sum + raw, SUM_LO, SUM_HI);
			cal_cnt = cal_cnt + 8'd1;
			head_acc = 0;
			o.calibrating = 1'b1;
			// last calibration sample: mean in LSB/256, truncated toward zero
			if (cal_cnt >= CALIB_N) begin
				q = (cal_sum * 256) / CALIB_N;
				ofs_q8 = clamp_to(q, OFS_LO, OFS_HI);
				cal_cnt = CNT_IDLE;
			end
		end else begin
			corr = raw * 256 - ofs_q8;
			head_acc = clamp_to(head_acc + corr * 5, HEAD_LO, HEAD_HI);
			o.rate = corr[RATE_W-1:0];
			o.heading = head_acc[HEAD_W-1:0];
		end
		return o;
	endfunction

	// random raw value: mostly full range, some extremes and small values
	function automatic logic signed [RAW_W-1:0] rand_raw();
		int mode;
		mode = $urandom_range(9);
		if (mode == 0)
			return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		if (mode == 1)
			return RAW_W'($urandom_range(16) - 8);
		return RAW_W'($urandom_range(16'hFFFF));
	endfunction

	// offer one item, optionally after idle cycles, and wait for its transfer
	task automatic send_item(input op_t op, input logic signed [RAW_W-1:0] raw);
		int gap;
		gap = 0;
		if (!no_idle) begin
			while ($urandom_range(99) < 31)
				gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample.kind = op;
		sample.raw_rate = raw;
		sample_valid = 1'b1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		expected_results.push_back(integrate_sample(sample));
		items_sent++;
	endtask

	// stop offering and wait until every expected result has come
	task automatic wait_results_done();
		@(negedge clk);
		sample_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// start command, then n samples spread around base
	task automatic calib_run(input int base, input int spread, input int n);
		int v;
		send_item(OP_START, rand_raw());
		for (int i = 0; i < n; i++) begin
			v = base + $urandom_range(2 * spread) - spread;
			send_item(OP_SAMPLE, RAW_W'(clamp_to(v, -32768, 32767)));
		end
	endtask

	// samples after reset with zero offset, field extremes
	task automatic test_idle_extremes();
		send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_SAMPLE, 16'sd0);
		send_item(OP_SAMPLE, 16'sd1);
		send_item(OP_SAMPLE, -16'sd1);
	endtask

	// start during a running calibration restarts it; extreme negative offset
	task automatic test_calib_restart();
		send_item(OP_START, 16'sh7FFF);
		repeat (5) send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_START, 16'sh8000);
		repeat (CALIB_N) send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_SAMPLE, 16'sh7FFF);
		send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_SAMPLE, 16'sd0);
	endtask

	// offset rounding toward zero for a negative sum, then extreme positive offset
	task automatic test_calib_rounding();
		send_item(OP_START, 16'sd0);
		repeat (CALIB_N - 1) send_item(OP_SAMPLE, 16'sd0);
		send_item(OP_SAMPLE, -16'sd1);
		send_item(OP_SAMPLE, 16'sd0);
		send_item(OP_SAMPLE, 16'sd3);
		calib_run(32767, 0, CALIB_N);
		send_item(OP_SAMPLE, 16'sh8000);
		send_item(OP_SAMPLE, 16'sh7FFF);
	endtask

	// receiver holds off while the sender keeps offering, then a full drain
	task automatic test_backpressure();
		hold_req = !hold_req;
		repeat (40) send_item(OP_SAMPLE, rand_raw());
		wait_results_done();
		calib_run(rand_raw(), 50, CALIB_N);
		wait_results_done();
	endtask

	// random segments: idle bursts, full calibrations and aborted ones
	task automatic test_random(input int n_items);
		int stop_at;
		int sel;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				calib_run(rand_raw(), $urandom_range(255), CALIB_N);
			end else if (sel < 13) begin
				calib_run(rand_raw(), $urandom_range(4000), $urandom_range(60));
			end else begin
				repeat ($urandom_range(1, 40)) send_item(OP_SAMPLE, rand_raw());
			end
		end
	endtask

	// stretch with no idling on either side
	task automatic test_no_idle();
		no_idle = 1'b1;
		test_random(150);
		no_idle = 1'b0;
	endtask

	// result receiver: random stalls plus a long hold-off on request
	initial begin
		int hold_left;
		bit seen;
		hold_left = 0;
		seen = 1'b0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != seen) begin
				seen = hold_req;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready = 1'b0;
			end else if (no_idle) begin
				result_ready = 1'b1;
			end else begin
				result_ready = ($urandom_range(99) >= 31);
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no expected result waiting");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.rate !== want.rate) begin
					$error("rate: expected %0d, got %0d", want.rate, result.rate);
					errors++;
				end
				if (result.heading !== want.heading) begin
					$error("heading: expected %0d, got %0d", want.heading, result.heading);
					errors++;
				end
				if (result.calibrating !== want.calibrating) begin
					$error("calibrating: expected %0b, got %0b", want.calibrating,
						result.calibrating);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// reset, tests in turn, end of run
	initial begin
		int waited;
		errors = 0;
		items_sent = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cal_cnt = CNT_IDLE;
		cal_sum = 0;
		ofs_q8 = 0;
		head_acc = 0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_idle_extremes();
		test_calib_restart();
		test_calib_rounding();
		wait_results_done();
		test_backpressure();
		test_random(330);
		test_no_idle();
		test_random(330);

		@(negedge clk);
		sample_valid = 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
